// ----- hw/rtl/quadrature_counter_with_period_speed_unit_defines.svh -----
// Assertion helpers used by the top-level file that checks this block.
`ifndef QUADRATURE_COUNTER_WITH_PERIOD_SPEED_UNIT_DEFINES_SVH
`define QUADRATURE_COUNTER_WITH_PERIOD_SPEED_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define QCPS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define QCPS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/qcps_pkg.sv -----
package qcps_pkg;

	// Configuration port.
	localparam int CFG_W     = 32;
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_PPR     = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MM      = 2'd2;

	localparam logic [15:0] PPR_RESET     = 16'd360;
	localparam logic [31:0] TIMEOUT_RESET = 32'd500000;
	localparam logic [31:0] MM_RESET      = 32'd65536;

	// Stream payload widths.
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 168;

	// 60e6 us/min times 256 for the Q24.8 result.
	localparam int SPEED_NUM_W = 34;
	localparam logic [SPEED_NUM_W-1:0] SPEED_NUM = 34'd15360000000;
	localparam int PROD_W      = 48;
	localparam int DIV_STEPS   = SPEED_NUM_W;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	typedef struct packed {
		logic load;
		logic update;
		logic mul;
		logic div_step;
		logic out_load;
	} qcps_cmd_t;

	typedef struct packed {
		logic out_free;
	} qcps_sts_t;

endpackage

// ----- hw/rtl/qcps_ctrl.sv -----
module qcps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  qcps_pkg::qcps_sts_t sts,
	output qcps_pkg::qcps_cmd_t cmd
);
	import qcps_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]           state_q;
	logic [2:0]           state_d;
	logic [DIV_CNT_W-1:0] cnt_q;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.load     = s_tvalid && (state_q == ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.update = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_DONE;
			end
			ST_DONE: begin
				// Hold the finished beat until the output register is free.
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.mul) cnt_q <= '0;
			else if (cmd.div_step) cnt_q <= cnt_q + DIV_CNT_W'(1);
		end
	end

endmodule

// ----- hw/rtl/qcps_dp.sv -----
module qcps_dp #(
	parameter int NUM_WHEELS = 2
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qcps_pkg::qcps_cmd_t                  cmd,
	output qcps_pkg::qcps_sts_t                  sts,
	input  logic                                 cfg_we,
	input  logic [qcps_pkg::REG_IDX_W-1:0]       cfg_addr,
	input  logic [qcps_pkg::CFG_W-1:0]           cfg_data,
	input  logic                                 s_tuser,
	input  logic [qcps_pkg::IN_TDATA_W-1:0]      s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [qcps_pkg::OUT_TDATA_W-1:0]     m_tdata
);
	import qcps_pkg::*;

	logic [15:0] ppr_q;
	logic [31:0] timeout_q;
	logic [31:0] mm_q;

	logic        wheel_q;
	logic        a_q;
	logic        b_q;
	logic        clr_q;
	logic [31:0] now_q;

	logic        prev_a_q [NUM_WHEELS];
	logic [31:0] count_q  [NUM_WHEELS];
	logic [31:0] last_q   [NUM_WHEELS];
	logic [31:0] period_q [NUM_WHEELS];

	logic        cur_prev_a;
	logic [31:0] cur_count;
	logic [31:0] cur_last;
	logic [31:0] cur_period;
	logic        wheel_ok;
	logic [31:0] nxt_count;
	logic [31:0] nxt_last;
	logic [31:0] nxt_period;
	logic [31:0] elapsed;
	logic        stale;
	logic [31:0] fin_period;
	logic        fin_stop;

	logic [31:0] res_count_q;
	logic [31:0] res_period_q;
	logic        res_stop_q;

	logic [15:0]         ppr_eff;
	logic [PROD_W-1:0]   prod_q;
	logic signed [64:0]  dist_full;
	logic [63:0]         dist_q;

	logic [PROD_W:0]        rem_q;
	logic [PROD_W:0]        rem_sh;
	logic [SPEED_NUM_W-1:0] quo_q;
	logic [31:0]            speed;

	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppr_q     <= PPR_RESET;
			timeout_q <= TIMEOUT_RESET;
			mm_q      <= MM_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_PPR:     ppr_q     <= cfg_data[15:0];
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_MM:      mm_q      <= cfg_data;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			wheel_q <= s_tuser;
			a_q     <= s_tdata[0];
			b_q     <= s_tdata[1];
			clr_q   <= s_tdata[2];
			now_q   <= s_tdata[34:3];
		end
	end

	always_comb begin
		cur_prev_a = 1'b1;
		cur_count  = '0;
		cur_last   = '0;
		cur_period = '0;
		for (int i = 0; i < NUM_WHEELS; i++) begin
			if (i == int'(wheel_q)) begin
				cur_prev_a = prev_a_q[i];
				cur_count  = count_q[i];
				cur_last   = last_q[i];
				cur_period = period_q[i];
			end
		end
	end

	assign wheel_ok = int'(wheel_q) < NUM_WHEELS;

	always_comb begin
		nxt_count  = cur_count;
		nxt_last   = cur_last;
		nxt_period = cur_period;
		if (clr_q) begin
			nxt_count  = '0;
			nxt_last   = '0;
			nxt_period = '0;
		end else if (a_q != cur_prev_a) begin
			nxt_count  = (a_q == b_q) ? cur_count + 32'd1 : cur_count - 32'd1;
			nxt_period = now_q - cur_last;
			nxt_last   = now_q;
		end
	end

	// The stale check sees the pulse time as updated by this beat.
	assign elapsed    = now_q - nxt_last;
	assign stale      = elapsed > timeout_q;
	assign fin_period = stale ? 32'd0 : nxt_period;
	assign fin_stop   = stale || (fin_period == 32'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				prev_a_q[i] <= 1'b1;
				count_q[i]  <= '0;
				last_q[i]   <= '0;
				period_q[i] <= '0;
			end
		end else if (cmd.update && wheel_ok) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				if (i == int'(wheel_q)) begin
					prev_a_q[i] <= a_q;
					count_q[i]  <= nxt_count;
					last_q[i]   <= nxt_last;
					period_q[i] <= fin_period;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_count_q  <= wheel_ok ? nxt_count : 32'd0;
			res_period_q <= wheel_ok ? fin_period : 32'd0;
			res_stop_q   <= wheel_ok ? fin_stop : 1'b1;
		end
	end

	assign ppr_eff   = (ppr_q == 16'd0) ? 16'd1 : ppr_q;
	assign dist_full = $signed({{33{res_count_q[31]}}, res_count_q}) * $signed({33'd0, mm_q});

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= {16'd0, res_period_q} * {32'd0, ppr_eff};
			dist_q <= dist_full[63:0];
		end
	end

	// Restoring division of the speed constant by period times pulses per rev,
	// one quotient bit per cycle shifted in behind the numerator bits.
	assign rem_sh = {rem_q[PROD_W-1:0], quo_q[SPEED_NUM_W-1]};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			rem_q <= '0;
			quo_q <= SPEED_NUM;
		end else if (cmd.div_step) begin
			if (rem_sh >= {1'b0, prod_q}) begin
				rem_q <= rem_sh - {1'b0, prod_q};
				quo_q <= {quo_q[SPEED_NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[SPEED_NUM_W-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		if (res_stop_q) speed = '0;
		else if (quo_q[SPEED_NUM_W-1:32] != '0) speed = '1;
		else speed = quo_q[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_tdata_q <= {7'd0, res_stop_q, dist_q, speed, res_period_q, res_count_q};
		end
	end

	assign sts.out_free = !m_tvalid_q || m_tready;
	assign m_tvalid     = m_tvalid_q;
	assign m_tdata      = m_tdata_q;

endmodule

// ----- hw/rtl/quadrature_counter_with_period_speed_unit.sv -----
// Two-phase quadrature counter with period-based speed for up to NUM_WHEELS
// wheels. Each input beat carries one wheel's A/B levels, a clear flag and a
// microsecond timestamp, and produces exactly one output beat with that
// wheel's position, pulse period, speed in Q24.8 RPM, distance in Q48.16 mm
// and a stopped flag. A beat holds the unit through the update, the multiply,
// the 34-step restoring divider that computes the speed and the output load; s_tready is high
// only between beats, but a new beat is taken while the previous result still
// waits in the output register. Wheel numbers at or above NUM_WHEELS leave
// all state alone and return zeros with stopped set. Configuration writes
// belong in idle time, when no beat is in flight.
`include "quadrature_counter_with_period_speed_unit_defines.svh"

module quadrature_counter_with_period_speed_unit #(
	parameter int NUM_WHEELS = 2
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [qcps_pkg::REG_IDX_W-1:0]   cfg_addr,
	input  logic [qcps_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// [0] phase_a, [1] phase_b, [2] clear, [34:3] now_us, [39:35] zero
	input  logic [qcps_pkg::IN_TDATA_W-1:0]  s_tdata,
	// [0] wheel
	input  logic                             s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// [31:0] position, [63:32] period_us, [95:64] speed_rpm_q8,
	// [159:96] distance_mm_q16, [160] stopped, [167:161] zero
	output logic [qcps_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import qcps_pkg::*;

	qcps_cmd_t cmd;
	qcps_sts_t sts;

	qcps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	qcps_dp #(
		.NUM_WHEELS (NUM_WHEELS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	`QCPS_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "accepted beat while busy")
	`QCPS_ASSERT_IMP(a_no_overwrite, cmd.out_load, !m_tvalid || m_tready, "pending result overwritten")
	`QCPS_ASSERT_IMP(a_stop_zero_speed, m_tvalid && m_tdata[160], m_tdata[95:64] == 32'd0, "stopped with speed")
	`QCPS_ASSERT_IMP(a_run_has_period, m_tvalid && !m_tdata[160], m_tdata[63:32] != 32'd0, "moving without period")

endmodule

// ----- tb/testbench.sv -----
module testbench;
	import qcps_pkg::*;

	typedef struct packed {
		logic        wheel;
		logic        a;
		logic        b;
		logic        clr;
		logic [31:0] now;
	} encoder_reading_t;

	// Same order as m_tdata[160:0], so a beat can be cast directly.
	typedef struct packed {
		logic        stopped;
		logic [63:0] distance;
		logic [31:0] speed;
		logic [31:0] period;
		logic [31:0] position;
	} wheel_result_t;

	typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

	typedef struct packed {
		row_kind_e              kind;
		logic [REG_IDX_W-1:0]   reg_sel;
		logic [31:0]            value;
		encoder_reading_t       reading;
		logic                   checked;
		wheel_result_t          want;
	} directed_row_t;

	typedef struct packed {
		logic [15:0] ppr;
		logic [31:0] timeout;
		logic [31:0] mm;
	} reg_set_t;

	localparam longint unsigned RPM_Q8_NUMERATOR = 64'd15360000000;
	localparam wheel_result_t STOPPED_IDLE = '{1'b1, 64'd0, 32'd0, 32'd0, 32'd0};
	localparam int NUM_DIRECTED = 30;
	localparam int NUM_PHASES = 6;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int HOLD_AFTER_BEATS = 300;
	localparam int HOLD_CYCLES = 400;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [REG_IDX_W-1:0]   cfg_addr;
	logic [CFG_W-1:0]       cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	// [0] phase_a, [1] phase_b, [2] clear, [34:3] now_us, [39:35] zero
	logic [IN_TDATA_W-1:0]  s_tdata;
	// [0] wheel
	logic                   s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	// [31:0] position, [63:32] period_us, [95:64] speed_rpm_q8,
	// [159:96] distance_mm_q16, [160] stopped, [167:161] zero
	logic [OUT_TDATA_W-1:0] m_tdata;

	// Model of the unit: configuration and per-wheel encoder state.
	logic [15:0] cfg_ppr = PPR_RESET;
	logic [31:0] cfg_timeout = TIMEOUT_RESET;
	logic [31:0] cfg_mm = MM_RESET;
	logic        enc_prev_a [2] = '{1'b1, 1'b1};
	logic [31:0] enc_count [2] = '{32'd0, 32'd0};
	logic [31:0] enc_last_us [2] = '{32'd0, 32'd0};
	logic [31:0] enc_period_us [2] = '{32'd0, 32'd0};

	wheel_result_t expected_readings [$];
	int mismatches = 0;
	int beats_in = 0;
	int beats_out = 0;
	bit steady_flow = 1'b0;

	directed_row_t directed_rows [NUM_DIRECTED] = '{
		// kind     reg          value          w     a     b     clr   now
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b1, 1'b0, 1'b0, 32'd0}, 1'b1, STOPPED_IDLE},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd1000}, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b1, 1'b1, 1'b0, 32'd2000}, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b0, 1'b1, 1'b0, 32'd2500}, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd2600}, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b0, 1'b1, 1'b0, 32'd5000}, 1'b0, '0},
		// Clear on the same beat as an A edge: no count is taken.
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b1, 1'b1, 1'b1, 32'd3000}, 1'b1, STOPPED_IDLE},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b1, 1'b1, 1'b0, 32'd3100}, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b1, 1'b1, 1'b0, 32'd600000}, 1'b0, '0},
		// One microsecond past the timeout.
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b1, 1'b0, 1'b0, 32'd1100001}, 1'b1, STOPPED_IDLE},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b0, 1'b0, 1'b0, 32'd4000}, 1'b0, '0},
		// Exactly at the timeout, still live.
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b0, 1'b1, 1'b0, 32'd504000}, 1'b0, '0},
		// Timestamp wraps between these A edges.
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFF0}, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b1, 1'b1, 1'b0, 32'h0000_0010}, 1'b0, '0},
		'{ROW_REG, REG_PPR, 32'd1, '0, 1'b0, '0},
		'{ROW_REG, REG_MM, 32'hFFFF_FFFF, '0, 1'b0, '0},
		// One-microsecond period with one pulse per rev saturates the speed.
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b0, 1'b1, 1'b0, 32'h11}, 1'b1,
			'{1'b0, 64'h0000_0000_FFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1}},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b1, 1'b0, 1'b0, 32'h13}, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b0, 1'b1, 1'b0, 32'h14}, 1'b1,
			'{1'b0, 64'hFFFF_FFFF_0000_0001, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF}},
		'{ROW_REG, REG_PPR, 32'd0, '0, 1'b0, '0},
		'{ROW_REG, REG_MM, 32'd0, '0, 1'b0, '0},
		'{ROW_REG, REG_TIMEOUT, 32'd0, '0, 1'b0, '0},
		// Edge with zero elapsed time gives a zero period.
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b1, 1'b1, 1'b0, 32'h14}, 1'b1, STOPPED_IDLE},
		// With a zero timeout any nonzero elapsed time is stale.
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b1, 1'b1, 1'b1, 1'b0, 32'h15}, 1'b1, STOPPED_IDLE},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b1, 1'b1, 1'b0, 32'h100}, 1'b0, '0},
		'{ROW_REG, REG_PPR, 32'd65535, '0, 1'b0, '0},
		'{ROW_REG, REG_TIMEOUT, 32'hFFFF_FFFF, '0, 1'b0, '0},
		'{ROW_REG, REG_MM, 32'd65536, '0, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h200}, 1'b0, '0},
		'{ROW_ITEM, REG_PPR, 32'd0, '{1'b0, 1'b0, 1'b1, 1'b0, 32'h1FF}, 1'b0, '0}
	};

	// The last phase draws its register values at run time.
	reg_set_t reg_sets [NUM_PHASES-1] = '{
		'{16'd360, 32'd500000, 32'd65536},
		'{16'd1, 32'd1000, 32'hFFFF_FFFF},
		'{16'd65535, 32'hFFFF_FFFF, 32'd1},
		'{16'd4096, 32'd2000, 32'h0001_8000},
		'{16'd0, 32'd0, 32'h1234_5678}
	};

	quadrature_counter_with_period_speed_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic wheel_result_t advance_wheel(input encoder_reading_t rd);
		wheel_result_t    res;
		logic [31:0]      elapsed;
		logic [63:0]      divisor;
		logic [63:0]      quotient;
		logic signed [63:0] pos_wide;
		logic signed [63:0] mm_wide;
		bit               stale;
		if (rd.clr) begin
			enc_count[rd.wheel] = '0;
			enc_last_us[rd.wheel] = '0;
			enc_period_us[rd.wheel] = '0;
		end else if (rd.a != enc_prev_a[rd.wheel]) begin
			if (rd.a == rd.b)
				enc_count[rd.wheel] = enc_count[rd.wheel] + 32'd1;
			else
				enc_count[rd.wheel] = enc_count[rd.wheel] - 32'd1;
			enc_period_us[rd.wheel] = rd.now - enc_last_us[rd.wheel];
			enc_last_us[rd.wheel] = rd.now;
		end
		enc_prev_a[rd.wheel] = rd.a;

		elapsed = rd.now - enc_last_us[rd.wheel];
		stale = elapsed > cfg_timeout;
		if (stale)
			enc_period_us[rd.wheel] = '0;

		res.position = enc_count[rd.wheel];
		res.period = enc_period_us[rd.wheel];
		res.stopped = stale || (res.period == 32'd0);
		res.speed = '0;
		if (!res.stopped) begin
			// A zero pulses-per-rev register divides as if it held one.
			divisor = {32'd0, res.period} * {48'd0, (cfg_ppr == 16'd0) ? 16'd1 : cfg_ppr};
			quotient = RPM_Q8_NUMERATOR / divisor;
			res.speed = (quotient > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quotient[31:0];
		end
		pos_wide = {{32{res.position[31]}}, res.position};
		mm_wide = {32'd0, cfg_mm};
		res.distance = pos_wide * mm_wide;
		return res;
	endfunction

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH beat %0d %s: got %h, expected %h", beats_out, field, got, want);
		mismatches++;
	endtask

	task automatic wait_drained();
		while (expected_readings.size() != 0)
			@(negedge clk);
	endtask

	// Called at a falling edge while the unit is idle; returns at a falling edge.
	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= value;
		case (idx)
			REG_PPR: cfg_ppr = value[15:0];
			REG_TIMEOUT: cfg_timeout = value;
			REG_MM: cfg_mm = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic offer(input encoder_reading_t rd, input bit fixed,
			input wheel_result_t fixed_want);
		wheel_result_t predicted;
		while (!steady_flow && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'd0, rd.now, rd.clr, rd.b, rd.a};
		s_tuser <= rd.wheel;
		do @(posedge clk); while (!s_tready);
		predicted = advance_wheel(rd);
		expected_readings.push_back(fixed ? fixed_want : predicted);
		beats_in++;
		@(negedge clk);
	endtask

	always @(posedge clk) begin : check_readings
		wheel_result_t got;
		wheel_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[160:0];
			if (expected_readings.size() == 0) begin
				report_mismatch("beat with nothing expected", got.position, 64'd0);
			end else begin
				want = expected_readings.pop_front();
				if (got.position !== want.position)
					report_mismatch("position", got.position, want.position);
				if (got.period !== want.period)
					report_mismatch("period_us", got.period, want.period);
				if (got.speed !== want.speed)
					report_mismatch("speed_rpm_q8", got.speed, want.speed);
				if (got.distance !== want.distance)
					report_mismatch("distance_mm_q16", got.distance, want.distance);
				if (got.stopped !== want.stopped)
					report_mismatch("stopped", got.stopped, want.stopped);
				if (m_tdata[OUT_TDATA_W-1:161] !== '0)
					report_mismatch("padding", m_tdata[OUT_TDATA_W-1:161], 64'd0);
			end
			beats_out++;
		end
	end

	// Output side: random stalls, plus one long hold-off that backs the unit up.
	initial begin : drive_ready
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!hold_done && beats_out >= HOLD_AFTER_BEATS) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= steady_flow || ($urandom_range(0, 99) >= 24);
			end
		end
	end

	initial begin : run_stimulus
		encoder_reading_t rd;
		reg_set_t         regs;
		logic [1:0]       enc_pos [2];
		bit               enc_back [2];
		logic [31:0]      clock_us;
		int               pick;
		logic             w;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		enc_pos = '{2'd0, 2'd0};
		enc_back = '{1'b0, 1'b0};
		clock_us = $urandom();

		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				s_tvalid <= 1'b0;
				wait_drained();
				write_reg(directed_rows[i].reg_sel, directed_rows[i].value);
			end else begin
				offer(directed_rows[i].reading, directed_rows[i].checked,
					directed_rows[i].want);
			end
		end
		s_tvalid <= 1'b0;

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			wait_drained();
			if (phase < NUM_PHASES - 1)
				regs = reg_sets[phase];
			else
				regs = '{16'($urandom_range(1, 65535)), $urandom_range(50, 200000), $urandom()};
			// The first phase runs with no idling on either side.
			steady_flow = (phase == 0);
			write_reg(REG_PPR, {16'd0, regs.ppr});
			write_reg(REG_TIMEOUT, regs.timeout);
			write_reg(REG_MM, regs.mm);

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					clock_us += $urandom_range(1, 3000);
				else if (pick < 70)
					clock_us += $urandom_range(0, 3);
				else if (pick < 92)
					clock_us += $urandom_range(0, 1200000);
				else
					clock_us += $urandom();

				w = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 99) < 4)
					enc_back[w] = !enc_back[w];
				pick = $urandom_range(0, 99);
				// Mostly clean Gray-code steps; the rest are resamples, glitches and clears.
				if (pick < 70)
					enc_pos[w] = enc_back[w] ? enc_pos[w] - 2'd1 : enc_pos[w] + 2'd1;
				rd.wheel = w;
				rd.now = clock_us;
				rd.a = ^enc_pos[w];
				rd.b = enc_pos[w][1];
				rd.clr = (pick >= 95);
				if (pick >= 90 && pick < 95) begin
					rd.a = 1'($urandom_range(0, 1));
					rd.b = 1'($urandom_range(0, 1));
				end
				offer(rd, 1'b0, '0);
			end
			s_tvalid <= 1'b0;
		end

		wait_drained();
		repeat (60) @(negedge clk);
		$display("Run covered %0d input beats and %0d result beats over %0d register settings,",
			beats_in, beats_out, NUM_PHASES + 3);
		$display("including a %0d-cycle output hold-off; %0d mismatches.",
			HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- quadrature_counter_with_period_speed_unit.f -----
+incdir+hw/rtl
hw/rtl/qcps_pkg.sv
hw/rtl/qcps_ctrl.sv
hw/rtl/qcps_dp.sv
hw/rtl/quadrature_counter_with_period_speed_unit.sv
tb/testbench.sv
